[rtl/xcfp_pkg.sv]
// ----------------------------------------------------------------------------
// xcfp_pkg
// Shared types, character codes and helpers for the XOR-checked frame parser.
// ----------------------------------------------------------------------------
package xcfp_pkg;

  // Default payload buffer size; frames keep at most one byte fewer.
  localparam int unsigned PayloadBufferDefault = 80;

  // Framing characters.
  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_LF    = 8'h0A;  // newline
  localparam logic [7:0] CH_CR    = 8'h0D;  // carriage return
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Number of checksum characters in a well-formed field.
  localparam logic [1:0] CSUM_CHARS = 2'd2;

  // Saturation limit of the reported payload length.
  localparam logic [6:0] LEN_MAX = 7'd127;

  // Packed widths of the output stream.
  localparam int unsigned OutDataWidth = 40;
  localparam int unsigned OutUserWidth = 2;

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_START = 2'd1,
    KIND_END   = 2'd2
  } xcfp_kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_BAD_FLD  = 2'd2,
    ST_NO_STAR  = 2'd3
  } xcfp_status_e;

  typedef struct packed {
    xcfp_kind_e   kind;
    logic [7:0]   data_byte;
    xcfp_status_e status;
    logic [6:0]   payload_length;
    logic [7:0]   computed_xor;
    logic [7:0]   received_xor;
  } xcfp_result_t;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, 4'(ch - 8'h30)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      r = {1'b1, 4'(ch - 8'h37)};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      r = {1'b1, 4'(ch - 8'h57)};
    end
    return r;
  endfunction

endpackage

[rtl/xor_checked_frame_parser.sv]
// ----------------------------------------------------------------------------
// xor_checked_frame_parser
// Parses '$' payload '*' HH newline frames and checks the payload XOR.
// ----------------------------------------------------------------------------
// Each byte passes through the input register, then its result through the result register.
// Throughput: one byte per cycle, limited only by the sink's tready.
// The input register and the result register are each one entry deep.
// Reset (rst_ni low, asynchronous) empties both registers and closes any
// open frame; the two stored checksum characters are not cleared.
// ----------------------------------------------------------------------------
module xor_checked_frame_parser #(
  parameter int unsigned PAYLOAD_BUFFER = xcfp_pkg::PayloadBufferDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream.
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [7:0]                          s_axis_tdata_i,  // [7:0] rx_byte
  // Result stream.
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [7:0] data_byte, [9:8] status, [16:10] payload_length,
  // [24:17] computed_xor, [32:25] received_xor, [39:33] zero
  output logic [xcfp_pkg::OutDataWidth-1:0]   m_axis_tdata_o,
  output logic [xcfp_pkg::OutUserWidth-1:0]   m_axis_tuser_o  // [1:0] kind
);

  import xcfp_pkg::*;

  logic         byte_valid;
  logic [7:0]   byte_val;
  logic         take;
  logic         res_valid;
  logic         out_free;
  xcfp_result_t res;
  xcfp_result_t out_res;

  // The held byte is consumed when it produces no result, or when the
  // result register is empty or being emptied this same cycle. Bytes that
  // are dropped or only update frame state never wait on the sink.
  assign take = byte_valid && (!res_valid || out_free);

  xcfp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_byte_i  (s_axis_tdata_i),
    .valid_o   (byte_valid),
    .byte_o    (byte_val),
    .pop_i     (take)
  );

  // The frame state updates only when the held byte is consumed, so a
  // stalled byte is evaluated again with unchanged state each cycle.
  xcfp_core #(
    .PAYLOAD_BUFFER (PAYLOAD_BUFFER)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_val),
    .take_i      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  xcfp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take && res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  // Pack the result fields onto the stream, lowest field in the lowest bits.
  assign m_axis_tdata_o = {7'd0,
                           out_res.received_xor,
                           out_res.computed_xor,
                           out_res.payload_length,
                           out_res.status,
                           out_res.data_byte};
  assign m_axis_tuser_o = out_res.kind;

endmodule

[rtl/xcfp_in_stage.sv]
// ----------------------------------------------------------------------------
// xcfp_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module xcfp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_byte_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  input  logic       pop_i
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // The slot can take a byte when empty or when its byte leaves this cycle.
  assign s_ready_o = !valid_q || pop_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= s_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

[rtl/xcfp_core.sv]
// ----------------------------------------------------------------------------
// xcfp_core
// Frame state and per-byte update: echo, frame start and frame verdict.
// ----------------------------------------------------------------------------
module xcfp_core #(
  parameter int unsigned PAYLOAD_BUFFER = xcfp_pkg::PayloadBufferDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           byte_i,
  input  logic                 take_i,
  output logic                 res_valid_o,
  output xcfp_pkg::xcfp_result_t res_o
);

  import xcfp_pkg::*;

  localparam int unsigned CW = $clog2(PAYLOAD_BUFFER);
  localparam logic [CW-1:0] StoreLimit = CW'(PAYLOAD_BUFFER - 1);

  logic          in_frame_q, in_frame_d;
  logic          in_csum_q, in_csum_d;
  logic [CW-1:0] stored_q, stored_d;
  logic [CW-1:0] eff_len_q, eff_len_d;
  logic          nul_seen_q, nul_seen_d;
  logic [7:0]    xor_q, xor_d;
  logic [1:0]    csum_cnt_q, csum_cnt_d;
  logic [7:0]    csum_chars_q [2];
  logic          csum_wr;

  logic [4:0]    hi_dig, lo_dig;
  logic [8:0]    eff_ext;
  logic [7:0]    rx_xor;
  logic          nul_now;

  assign hi_dig  = hex_digit(csum_chars_q[0]);
  assign lo_dig  = hex_digit(csum_chars_q[1]);
  assign rx_xor  = {hi_dig[3:0], lo_dig[3:0]};
  assign eff_ext = 9'(eff_len_q);
  assign nul_now = nul_seen_q || (byte_i == CH_NUL);

  always_comb begin
    in_frame_d  = in_frame_q;
    in_csum_d   = in_csum_q;
    stored_d    = stored_q;
    eff_len_d   = eff_len_q;
    nul_seen_d  = nul_seen_q;
    xor_d       = xor_q;
    csum_cnt_d  = csum_cnt_q;
    csum_wr     = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (byte_i == CH_START) begin
      // A start marker always opens a fresh frame, dropping any open one.
      in_frame_d  = 1'b1;
      in_csum_d   = 1'b0;
      stored_d    = '0;
      eff_len_d   = '0;
      nul_seen_d  = 1'b0;
      xor_d       = '0;
      csum_cnt_d  = '0;
      res_valid_o = 1'b1;
      res_o.kind  = KIND_START;
    end else if (in_frame_q && byte_i != CH_CR) begin
      if (byte_i == CH_LF) begin
        res_valid_o          = 1'b1;
        res_o.kind           = KIND_END;
        res_o.computed_xor   = xor_q;
        res_o.payload_length = (eff_ext > 9'(LEN_MAX)) ? LEN_MAX : eff_ext[6:0];
        if (!in_csum_q) begin
          res_o.status = ST_NO_STAR;
        end else if (csum_cnt_q != CSUM_CHARS || !hi_dig[4] || !lo_dig[4]) begin
          res_o.status = ST_BAD_FLD;
        end else begin
          res_o.received_xor = rx_xor;
          res_o.status       = (rx_xor == xor_q) ? ST_OK : ST_MISMATCH;
        end
        in_frame_d = 1'b0;
        in_csum_d  = 1'b0;
        stored_d   = '0;
        eff_len_d  = '0;
        nul_seen_d = 1'b0;
        xor_d      = '0;
        csum_cnt_d = '0;
      end else if (byte_i == CH_STAR) begin
        in_csum_d = 1'b1;
      end else if (in_csum_q) begin
        if (csum_cnt_q < CSUM_CHARS) begin
          csum_wr    = 1'b1;
          csum_cnt_d = csum_cnt_q + 2'd1;
        end
      end else if (stored_q < StoreLimit) begin
        stored_d   = stored_q + CW'(1);
        nul_seen_d = nul_now;
        if (!nul_now) begin
          xor_d           = xor_q ^ byte_i;
          eff_len_d       = eff_len_q + CW'(1);
          res_valid_o     = 1'b1;
          res_o.kind      = KIND_ECHO;
          res_o.data_byte = byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      in_csum_q  <= 1'b0;
      stored_q   <= '0;
      eff_len_q  <= '0;
      nul_seen_q <= 1'b0;
      xor_q      <= '0;
      csum_cnt_q <= '0;
    end else if (take_i) begin
      in_frame_q <= in_frame_d;
      in_csum_q  <= in_csum_d;
      stored_q   <= stored_d;
      eff_len_q  <= eff_len_d;
      nul_seen_q <= nul_seen_d;
      xor_q      <= xor_d;
      csum_cnt_q <= csum_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && csum_wr) begin
      csum_chars_q[csum_cnt_q[0]] <= byte_i;
    end
  end

endmodule

[rtl/xcfp_out_reg.sv]
// ----------------------------------------------------------------------------
// xcfp_out_reg
// Result register: holds one finished result until the sink takes it.
// ----------------------------------------------------------------------------
module xcfp_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  xcfp_pkg::xcfp_result_t res_i,
  output logic                   free_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output xcfp_pkg::xcfp_result_t res_o
);

  import xcfp_pkg::*;

  logic         valid_q, valid_d;
  xcfp_result_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
